// ===== design/prle_pkg.sv =====
// shared types and constants of the palette run-length encoder
package prle_pkg;

	// count width of the wide mode, between 8 and 16
	localparam int COUNT_BITS = 16;
	localparam int LENGTH_BITS = 16;
	localparam int VALUE_BITS = 8;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [LENGTH_BITS-1:0] NARROW_CAP = LENGTH_BITS'(255);
	localparam logic [LENGTH_BITS-1:0] WIDE_CAP = LENGTH_BITS'((32'd1 << COUNT_BITS) - 32'd1);
	localparam logic [LENGTH_BITS-1:0] WIDTH_RESET = LENGTH_BITS'(320);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_WIDE_COUNTS = 2'd0,
		REG_ROWED_MODE  = 2'd1,
		REG_IMAGE_WIDTH = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [LENGTH_BITS-1:0] length;
		logic [VALUE_BITS-1:0]  value;
		logic                   final_flag;
	} run_word_t;

	// up to two run words from one pixel, older one in word0
	typedef struct packed {
		logic      wr0;
		logic      wr1;
		run_word_t word0;
		run_word_t word1;
	} push_t;

endpackage

// ===== design/prle_front.sv =====
// front part: config registers, run tracking and run word generation
module prle_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [prle_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [prle_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                pixel_valid,
	output logic                                pixel_ready,
	input  logic [prle_pkg::VALUE_BITS-1:0]     pixel_in,
	input  logic                                last_pixel,
	input  logic                                room,
	output prle_pkg::push_t                     push
);

	logic                             wide_counts_q;
	logic                             rowed_mode_q;
	logic [prle_pkg::LENGTH_BITS-1:0] image_width_q;
	logic [prle_pkg::VALUE_BITS-1:0]  held_value_q;
	logic [prle_pkg::LENGTH_BITS-1:0] run_count_q;
	logic [prle_pkg::LENGTH_BITS-1:0] column_pos_q;

	logic                             accept;
	logic [prle_pkg::LENGTH_BITS-1:0] cap;
	logic                             flush_old;
	logic [prle_pkg::LENGTH_BITS-1:0] new_count;
	logic [prle_pkg::VALUE_BITS-1:0]  new_value;
	logic [prle_pkg::LENGTH_BITS-1:0] col_next;
	logic                             row_end;
	logic                             close_new;

	assign cfg_ready = 1'b1;
	assign pixel_ready = room;
	assign accept = pixel_valid && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_counts_q <= 1'b0;
			rowed_mode_q <= 1'b0;
			image_width_q <= prle_pkg::WIDTH_RESET;
		end else if (cfg_valid) begin
			unique case (prle_pkg::cfg_reg_t'(cfg_index))
				prle_pkg::REG_WIDE_COUNTS: wide_counts_q <= cfg_data[0];
				prle_pkg::REG_ROWED_MODE:  rowed_mode_q <= cfg_data[0];
				prle_pkg::REG_IMAGE_WIDTH: image_width_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cap = wide_counts_q ? prle_pkg::WIDE_CAP : prle_pkg::NARROW_CAP;
		// open run closes first on a new value or a count already at the cap
		flush_old = (run_count_q != '0) &&
			((pixel_in != held_value_q) || (run_count_q >= cap));
		if (flush_old || (run_count_q == '0)) begin
			new_count = prle_pkg::LENGTH_BITS'(1);
			new_value = pixel_in;
		end else begin
			new_count = run_count_q + prle_pkg::LENGTH_BITS'(1);
			new_value = held_value_q;
		end
		col_next = column_pos_q + prle_pkg::LENGTH_BITS'(1);
		row_end = (col_next == image_width_q);
		close_new = (new_count >= cap) || (rowed_mode_q && row_end) || last_pixel;

		push.wr0 = accept && flush_old;
		push.wr1 = accept && close_new;
		push.word0.length = run_count_q;
		push.word0.value = held_value_q;
		push.word0.final_flag = 1'b0;
		push.word1.length = new_count;
		push.word1.value = new_value;
		push.word1.final_flag = last_pixel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_value_q <= '0;
			run_count_q <= '0;
			column_pos_q <= '0;
		end else if (accept) begin
			held_value_q <= new_value;
			run_count_q <= close_new ? '0 : new_count;
			column_pos_q <= (row_end || last_pixel) ? '0 : col_next;
		end
	end

	a_image_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_pixel |=> (run_count_q == '0) && (column_pos_q == '0))
		else $error("state not cleared after final pixel");

	a_no_empty_run: assert property (@(posedge clk) disable iff (!arst_n)
		push.wr0 || push.wr1 |->
			(!push.wr0 || push.word0.length != '0) && (push.word1.length != '0))
		else $error("run word with zero length");

endmodule

// ===== design/prle_queue.sv =====
// back part: short run word queue, two writes and one read per cycle
module prle_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  prle_pkg::push_t              push,
	output logic                         room,
	output logic                         run_valid,
	input  logic                         run_ready,
	output prle_pkg::run_word_t          head
);

	localparam int PB = prle_pkg::QPTR_BITS;
	localparam int CB = prle_pkg::QCOUNT_BITS;

	prle_pkg::run_word_t mem_q [prle_pkg::QUEUE_DEPTH];
	logic [PB-1:0] wr_ptr_q;
	logic [PB-1:0] rd_ptr_q;
	logic [CB-1:0] count_q;

	logic [CB-1:0]       n_push;
	logic                pop;
	prle_pkg::run_word_t first_word;
	logic [PB-1:0]       wr_ptr_next;

	assign n_push = CB'(push.wr0) + CB'(push.wr1);
	assign pop = run_valid && run_ready;
	assign run_valid = (count_q != '0);
	assign head = mem_q[rd_ptr_q];
	// room for two words, so the worst pixel never overruns
	assign room = (count_q <= CB'(prle_pkg::QUEUE_DEPTH - 2));
	assign first_word = push.wr0 ? push.word0 : push.word1;
	assign wr_ptr_next = wr_ptr_q + PB'(1);

	always_ff @(posedge clk) begin
		if (push.wr0 || push.wr1) begin
			mem_q[wr_ptr_q] <= first_word;
		end
		if (push.wr0 && push.wr1) begin
			mem_q[wr_ptr_next] <= push.word1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push[PB-1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PB'(1);
			end
			count_q <= count_q + n_push - CB'(pop);
		end
	end

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CB'(prle_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.wr0 || push.wr1 |-> count_q + n_push <= CB'(prle_pkg::QUEUE_DEPTH))
		else $error("queue overrun");

endmodule

// ===== design/palette_run_length_encoder_unit.sv =====
// top level of the palette run-length encoder
//
//  channel | direction | handshake               | word
//  cfg     | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//  pixel   | in        | pixel_valid / pixel_ready | pixel_in, last_pixel
//  run     | out       | run_valid / run_ready   | run_length, run_value, final_run
//
// one pixel per clock while ready; a pixel closing two runs queues two words
// four-entry queue drains one word per clock on run_ready, which sets the rate
// pixel_ready drops when fewer than two queue entries are free
// run words appear in the cycle after their pixel at the earliest
// reset clears config to narrow counts, unrowed, width 320, with no open run
module palette_run_length_encoder_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [prle_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [prle_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                pixel_valid,
	output logic                                pixel_ready,
	input  logic [prle_pkg::VALUE_BITS-1:0]     pixel_in,
	input  logic                                last_pixel,
	output logic                                run_valid,
	input  logic                                run_ready,
	output logic [prle_pkg::LENGTH_BITS-1:0]    run_length,
	output logic [prle_pkg::VALUE_BITS-1:0]     run_value,
	output logic                                final_run
);

	prle_pkg::push_t     push;
	prle_pkg::run_word_t head;
	logic                room;

	prle_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel_in    (pixel_in),
		.last_pixel  (last_pixel),
		.room        (room),
		.push        (push)
	);

	prle_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.run_valid (run_valid),
		.run_ready (run_ready),
		.head      (head)
	);

	assign run_length = head.length;
	assign run_value = head.value;
	assign final_run = head.final_flag;

endmodule
